/* hw/rtl/pli_pkg.sv */
package pli_pkg;

  // widest index a cell needs, covers the largest supported depth
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  typedef enum logic {
    FN_ADD = 1'b0,
    FN_DEL = 1'b1
  } func_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } ctl_t;

endpackage

/* hw/rtl/pli_cell.sv */
module pli_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                       clk,
  input  pli_pkg::ctl_t              ctl,
  input  logic [pli_pkg::DATA_W-1:0] left_q,
  input  logic [pli_pkg::DATA_W-1:0] right_q,
  output logic [pli_pkg::DATA_W-1:0] q,
  output logic [pli_pkg::DATA_W-1:0] tap
);

  localparam logic [pli_pkg::IDX_W-1:0] IDX = pli_pkg::IDX_W'(INDEX);

  logic [pli_pkg::DATA_W-1:0] data_r;
  logic [pli_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      pli_pkg::OP_INS: begin
        if (IDX == ctl.at) begin
          data_nxt = ctl.value;
        end else if (IDX > ctl.at) begin
          data_nxt = left_q;
        end
      end
      pli_pkg::OP_DEL: begin
        if (IDX >= ctl.at) begin
          data_nxt = right_q;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q   = data_r;
  // only the cell being removed shows its word
  assign tap = ((ctl.op == pli_pkg::OP_DEL) && (IDX == ctl.at)) ? data_r : '0;

endmodule

/* hw/rtl/pli_ctrl.sv */
module pli_ctrl #(
  parameter int unsigned DEPTH = pli_pkg::DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       go,
  input  logic                       func,
  input  logic [pli_pkg::DATA_W-1:0] value,
  input  logic [pli_pkg::POS_W-1:0]  position,
  input  logic                       after,
  input  logic [CNT_W-1:0]           cnt,
  output pli_pkg::ctl_t              ctl,
  output pli_pkg::status_t           status,
  output logic [CNT_W-1:0]           cnt_nxt
);

  localparam int unsigned CMP_W = CNT_W + pli_pkg::POS_W;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] at_w;
  logic             pos_bad;

  always_comb begin
    pos_w   = CMP_W'(position);
    cnt_w   = CMP_W'(cnt);
    pos_bad = (pos_w == '0) || (pos_w > cnt_w);
    at_w    = '0;
    status  = pli_pkg::ST_OK;
    cnt_nxt = cnt;
    ctl.op  = pli_pkg::OP_HOLD;
    ctl.value = value;
    if (func == pli_pkg::FN_ADD) begin
      if (cnt == '0) begin
        ctl.op  = pli_pkg::OP_INS;
        cnt_nxt = CNT_W'(1);
      end else if (cnt == CNT_W'(DEPTH)) begin
        status = pli_pkg::ST_FULL;
      end else if (pos_bad) begin
        status = pli_pkg::ST_RANGE;
      end else begin
        ctl.op  = pli_pkg::OP_INS;
        at_w    = after ? pos_w : pos_w - CMP_W'(1);
        cnt_nxt = cnt + CNT_W'(1);
      end
    end else begin
      if (cnt == '0) begin
        status = pli_pkg::ST_EMPTY;
      end else if (cnt == CNT_W'(1)) begin
        ctl.op  = pli_pkg::OP_DEL;
        cnt_nxt = '0;
      end else if (pos_bad) begin
        status = pli_pkg::ST_RANGE;
      end else begin
        ctl.op  = pli_pkg::OP_DEL;
        at_w    = pos_w - CMP_W'(1);
        cnt_nxt = cnt - CNT_W'(1);
      end
    end
    ctl.at = at_w[pli_pkg::IDX_W-1:0];
    if (!go) begin
      ctl.op = pli_pkg::OP_HOLD;
    end
  end

endmodule

/* hw/rtl/positional_list_insert_delete.sv */
// a result word is registered and appears on out_ in the cycle after its input word is taken
// throughput: one word per cycle while the result slot is free or draining; the whole cell chain shifts together
// the output register holds one result, so input stalls only while it waits unread
// reset: synchronous active-low rst_n empties the list and drops the output valid
// stored values are not cleared; entries past the count are never read
module positional_list_insert_delete #(
  parameter int unsigned DEPTH = pli_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[36:32], after[37], zero pad
  input  logic        in_tuser,   // func (0 add, 1 delete)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // count[4:0], removed_value[36:5], zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // list length
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_calc;

  // result register
  logic                       vld_r;
  logic                       vld_nxt;
  logic [1:0]                 status_r;
  logic [4:0]                 count_r;
  logic [pli_pkg::DATA_W-1:0] removed_r;

  logic                       accept;
  pli_pkg::ctl_t              ctl;
  pli_pkg::status_t           status;
  logic [pli_pkg::DATA_W-1:0] removed;
  logic [CNT_W+4:0]           cnt_ext;

  // cell chain wiring
  logic [pli_pkg::DATA_W-1:0] cell_q   [DEPTH];
  logic [pli_pkg::DATA_W-1:0] cell_tap [DEPTH];

  // take a new word whenever the result slot is free or being drained
  assign in_tready = !vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // decode the word into a chain command, status and new length
  pli_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .go       (accept),
    .func     (in_tuser),
    .value    (in_tdata[31:0]),
    .position (in_tdata[36:32]),
    .after    (in_tdata[37]),
    .cnt      (cnt_r),
    .ctl      (ctl),
    .status   (status),
    .cnt_nxt  (cnt_calc)
  );

  // cells past the insert point take their left neighbor, cells from the delete point on their right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [pli_pkg::DATA_W-1:0] left_q;
    logic [pli_pkg::DATA_W-1:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    pli_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .tap     (cell_tap[i])
    );
  end

  // at most one cell taps its word out, the rest give zero
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | cell_tap[i];
    end
  end

  assign cnt_nxt = accept ? cnt_calc : cnt_r;
  assign vld_nxt = accept ? 1'b1 : (out_tready ? 1'b0 : vld_r);
  assign cnt_ext = (CNT_W + 5)'(cnt_calc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status;
      count_r   <= cnt_ext[4:0];
      removed_r <= removed;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, removed_r, count_r};

endmodule

/* bench/tb.sv */
module tb;

  localparam int unsigned LIST_DEPTH = pli_pkg::DEPTH_DEF;

  // one expected result word, fields as the block reports them
  typedef struct packed {
    pli_pkg::status_t                 status;
    logic [pli_pkg::POS_W-1:0]        count;
    logic [pli_pkg::DATA_W-1:0]       removed;
  } list_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // value[31:0], position[36:32], after[37], zero pad
  logic        in_tuser   = 1'b0; // func (0 add, 1 delete)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // count[4:0], removed_value[36:5], zero pad
  logic [1:0]  out_tuser;         // status

  // shadow copy of the list, packed from index 0 up
  logic [pli_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
  int unsigned                list_len;

  list_result_t result_q [$];
  int           mismatches;
  int           in_calm;
  int           out_calm;

  positional_list_insert_delete #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 4 unit period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("FAIL positional_list_insert_delete");
    $finish;
  end

  // idle cycles before the next word; now and then a run with no idling at all
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // values lean on the signed extremes, zero and all ones
  function automatic logic [pli_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // list update for one word, returns what the block should report
  function automatic list_result_t apply_list_op(pli_pkg::func_t fn,
                                                 logic [pli_pkg::DATA_W-1:0] val,
                                                 logic [pli_pkg::POS_W-1:0] pos, logic aft);
    list_result_t r;
    int unsigned  slot;
    int unsigned  i;
    r.status  = pli_pkg::ST_OK;
    r.removed = '0;
    if (fn == pli_pkg::FN_ADD) begin
      if (list_len == 0) begin
        // empty list takes the value as entry one, position ignored
        list_mem[0] = val;
        list_len    = 1;
      end else if (list_len >= LIST_DEPTH) begin
        r.status = pli_pkg::ST_FULL;
      end else if (pos < 1 || pos > list_len) begin
        r.status = pli_pkg::ST_RANGE;
      end else begin
        slot = aft ? pos : pos - 1;
        for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
        list_mem[slot] = val;
        list_len++;
      end
    end else begin
      if (list_len == 0) begin
        r.status = pli_pkg::ST_EMPTY;
      end else if (list_len == 1) begin
        // single entry goes whatever the position
        r.removed = list_mem[0];
        list_len  = 0;
      end else if (pos < 1 || pos > list_len) begin
        r.status = pli_pkg::ST_RANGE;
      end else begin
        r.removed = list_mem[pos-1];
        for (i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
      end
    end
    r.count = pli_pkg::POS_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %08h expected %08h", what, got, want);
  endtask

  // drive one word and wait for it to be taken; valid stays up when no gap follows
  task automatic send_word(input pli_pkg::func_t fn, input logic [pli_pkg::DATA_W-1:0] val,
                           input logic [pli_pkg::POS_W-1:0] pos, input logic aft);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, aft, pos, val};
    // ready is settled mid-cycle, so the handshake lands on the next edge
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    result_q.push_back(apply_list_op(fn, val, pos, aft));
  endtask

  // stop offering words, then wait for every expected result
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // position that mostly hits the live range, sometimes zero, just past the end or far out
  function automatic logic [pli_pkg::POS_W-1:0] pick_position();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return pli_pkg::POS_W'(list_len + 1);
      2: return pli_pkg::POS_W'($urandom_range(17, 31));
      3: return pli_pkg::POS_W'(LIST_DEPTH);
      default: begin
        if (list_len == 0) return pli_pkg::POS_W'($urandom_range(0, 31));
        return pli_pkg::POS_W'($urandom_range(1, list_len));
      end
    endcase
  endfunction

  // result side: random stalls, compare each accepted word with the oldest expectation
  initial begin : result_check
    int           gap;
    list_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      if (result_q.size() == 0) begin
        report_mismatch("result word with nothing expected", out_tdata[31:0], '0);
      end else begin
        want = result_q.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[4:0] !== want.count)
          report_mismatch("count", 32'(out_tdata[4:0]), 32'(want.count));
        if (out_tdata[36:5] !== want.removed)
          report_mismatch("removed value", out_tdata[36:5], want.removed);
        if (out_tdata[39:37] !== 3'b000)
          report_mismatch("pad bits", 32'(out_tdata[39:37]), '0);
      end
      @(posedge clk);
    end
  end

  // corner cases on a small list: empty, single entry, ends, bad positions
  task automatic test_directed();
    send_word(pli_pkg::FN_DEL, 32'h1234_5678, 5'd0,  1'b0);  // delete from empty
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd16, 1'b1);  // delete from empty, high position
    send_word(pli_pkg::FN_ADD, 32'h8000_0000, 5'd0,  1'b1);  // empty list ignores position zero
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd31, 1'b0);  // single entry leaves anyway
    send_word(pli_pkg::FN_ADD, 32'h7fff_ffff, 5'd16, 1'b0);  // empty list ignores sixteen
    send_word(pli_pkg::FN_ADD, 32'h1,         5'd0,  1'b0);  // position zero refused
    send_word(pli_pkg::FN_ADD, 32'h2,         5'd2,  1'b1);  // just past the end refused
    send_word(pli_pkg::FN_ADD, 32'hffff_ffff, 5'd1,  1'b0);  // before the head
    send_word(pli_pkg::FN_ADD, 32'h0,         5'd2,  1'b1);  // after the tail
    send_word(pli_pkg::FN_ADD, 32'h5a5a_a5a5, 5'd1,  1'b1);  // after the head
    send_word(pli_pkg::FN_ADD, 32'ha5a5_5a5a, 5'd4,  1'b0);  // before the tail
    send_word(pli_pkg::FN_DEL, 32'hdead_beef, 5'd0,  1'b0);  // delete position zero refused
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd6,  1'b1);  // delete past the end refused
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd5,  1'b0);  // delete the tail
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd1,  1'b1);  // delete the head
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd2,  1'b0);  // delete from the middle
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd3,  1'b0);  // past the end of two refused
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd1,  1'b0);
    send_word(pli_pkg::FN_DEL, 32'h0,         5'd1,  1'b0);
  endtask

  // fill to the top, push against it, then empty it at random positions
  task automatic test_full_list();
    while (list_len < LIST_DEPTH)
      send_word(pli_pkg::FN_ADD, pick_value(),
                pli_pkg::POS_W'($urandom_range(1, list_len > 0 ? list_len : 1)),
                1'($urandom_range(0, 1)));
    send_word(pli_pkg::FN_ADD, pick_value(), 5'd0,  1'b0);   // full beats bad position
    send_word(pli_pkg::FN_ADD, pick_value(), 5'd16, 1'b1);
    send_word(pli_pkg::FN_ADD, pick_value(), 5'd1,  1'b0);
    send_word(pli_pkg::FN_DEL, 32'h0,        5'd17, 1'b0);   // one past a full list
    send_word(pli_pkg::FN_DEL, 32'h0,        5'd16, 1'b0);   // last slot of a full list
    send_word(pli_pkg::FN_ADD, pick_value(), 5'd15, 1'b1);   // refill the top slot
    send_word(pli_pkg::FN_DEL, 32'h0,        5'd1,  1'b0);
    send_word(pli_pkg::FN_ADD, pick_value(), 5'd1,  1'b0);   // head insert shifts everything
    while (list_len > 0)
      send_word(pli_pkg::FN_DEL, pick_value(), pli_pkg::POS_W'($urandom_range(1, list_len)),
                1'($urandom_range(0, 1)));
    send_word(pli_pkg::FN_DEL, 32'h0, 5'd1, 1'b0);
  endtask

  // pause the sender until the list has reported every word
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(4, 12))
        send_word(pli_pkg::func_t'($urandom_range(0, 1)), pick_value(), pick_position(),
                  1'($urandom_range(0, 1)));
      wait_drain();
    end
  endtask

  // long walk; add-heavy and delete-heavy stretches swing the count between empty and full
  task automatic test_random_walk(input int n_words);
    int             add_pct;
    pli_pkg::func_t fn;
    add_pct = 75;
    for (int n = 0; n < n_words; n++) begin
      if ((n % 60) == 0)
        add_pct = (add_pct > 50) ? $urandom_range(15, 35) : $urandom_range(65, 85);
      fn = ($urandom_range(0, 99) < add_pct) ? pli_pkg::FN_ADD : pli_pkg::FN_DEL;
      send_word(fn, pick_value(), pick_position(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 199) == 0) wait_drain();
    end
  endtask

  initial begin : stimulus
    list_len   = 0;
    mismatches = 0;
    in_calm    = 0;
    out_calm   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_list();
    test_drain_pause();
    test_random_walk(1350);

    in_tvalid <= 1'b0;
    wait_drain();
    // room for a stray extra word to show up
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS positional_list_insert_delete");
    end else begin
      $display("FAIL positional_list_insert_delete");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pli_pkg.sv
hw/rtl/pli_cell.sv
hw/rtl/pli_ctrl.sv
hw/rtl/positional_list_insert_delete.sv
bench/tb.sv
